// File: design/rmeu_pkg.sv
// ----------------------------------------------------------------------------
// rmeu_pkg
// Shared types and constants of the register machine execute unit: command
// codes, the classified item that passes from front to back, and the result.
// ----------------------------------------------------------------------------
package rmeu_pkg;

   localparam int WordWidth   = 16;
   localparam int RegIdxWidth = 3;
   localparam int FrontDepth  = 4;
   localparam int OutDepth    = 2;

   typedef enum logic [3:0] {
      CMD_LOAD   = 4'd0,
      CMD_MOV    = 4'd1,
      CMD_ADD    = 4'd2,
      CMD_SUB    = 4'd3,
      CMD_MUL    = 4'd4,
      CMD_HALT   = 4'd5,
      CMD_LOADM  = 4'd6,
      CMD_STOREM = 4'd7,
      CMD_CMP    = 4'd8,
      CMD_PUSH   = 4'd9,
      CMD_JMP    = 4'd10,
      CMD_JZ     = 4'd11,
      CMD_POP    = 4'd12,
      CMD_CALL   = 4'd13,
      CMD_RET    = 4'd14
   } cmd_type;

   // classified instruction, register indexes already wrapped to the file size
   typedef struct packed {
      cmd_type                cmd;
      logic [RegIdxWidth-1:0] ra;
      logic [RegIdxWidth-1:0] rb;
      logic [WordWidth-1:0]   operand;
      logic [WordWidth-1:0]   mem_addr;  // operand wrapped to the memory size
      logic                   mem_rd;    // reads data memory
      logic                   use_sp;    // memory read goes to the stack top
   } dec_item_type;

   typedef struct packed {
      logic         valid;
      dec_item_type item;
   } front_out_type;

   typedef struct packed {
      logic [WordWidth-1:0] written_value;
      logic [WordWidth-1:0] program_counter;
      logic [WordWidth-1:0] stack_pointer;
      logic                 zero_flag;
      logic                 halted_flag;
   } rsp_item_type;

endpackage

// File: design/register_machine_execute_unit_core.sv
// ----------------------------------------------------------------------------
// register_machine_execute_unit_core
// Steps: an accepted item is classified, its register indexes wrapped and its
// address reduction started into a stage register; the reduction finishes
// as the item enters the front queue. The back end reads the register file
// and data memory as it takes an item, then executes it, and takes no new
// item until the last one has executed. Synchronous reset clears the queues,
// registers, flags and register valid bits, not register file or data memory.
// ----------------------------------------------------------------------------
module register_machine_execute_unit_core #(
   parameter int REG_COUNT = 8,
   parameter int MEM_WORDS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [3:0]  req_command,
   input  logic [2:0]  req_first_reg,
   input  logic [2:0]  req_second_reg,
   input  logic [15:0] req_operand_word,
   output logic        empty,
   input  logic        pop,
   output logic [15:0] rsp_written_value,
   output logic [15:0] rsp_program_counter,
   output logic [15:0] rsp_stack_pointer,
   output logic        rsp_zero_flag,
   output logic        rsp_halted_flag
);

   import rmeu_pkg::*;

   front_out_type front_out;
   logic          item_take;

   rmeu_front #(
      .REG_COUNT (REG_COUNT),
      .MEM_WORDS (MEM_WORDS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_command      (req_command),
      .req_first_reg    (req_first_reg),
      .req_second_reg   (req_second_reg),
      .req_operand_word (req_operand_word),
      .item_take        (item_take),
      .front_out        (front_out)
   );

   rmeu_back #(
      .REG_COUNT (REG_COUNT),
      .MEM_WORDS (MEM_WORDS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .front_out           (front_out),
      .item_take           (item_take),
      .pop                 (pop),
      .empty               (empty),
      .rsp_written_value   (rsp_written_value),
      .rsp_program_counter (rsp_program_counter),
      .rsp_stack_pointer   (rsp_stack_pointer),
      .rsp_zero_flag       (rsp_zero_flag),
      .rsp_halted_flag     (rsp_halted_flag)
   );

endmodule

// File: design/rmeu_ram.sv
// ----------------------------------------------------------------------------
// rmeu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmeu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/rmeu_fifo.sv
// ----------------------------------------------------------------------------
// rmeu_fifo
// Small register-based queue with fill level.
// ----------------------------------------------------------------------------
module rmeu_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic                       full,
   output logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int PtrWidth   = $clog2(DEPTH);
   localparam int LevelWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(DEPTH - 1);
   localparam logic [LevelWidth-1:0] FullLevel = LevelWidth'(DEPTH);

   logic [WIDTH-1:0]      entry_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LevelWidth-1:0] level_ff, level_in;
   logic                  do_push, do_pop;

   assign empty    = (level_ff == '0);
   assign full     = (level_ff == FullLevel);
   assign level    = level_ff;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // advance pointers and level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // hold payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/rmeu_front.sv
// ----------------------------------------------------------------------------
// rmeu_front
// Accepts instructions, wraps register indexes and the memory address to the
// configured sizes, classifies memory use and queues the result for the back.
// ----------------------------------------------------------------------------
module rmeu_front #(
   parameter int REG_COUNT = 8,
   parameter int MEM_WORDS = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [3:0]             req_command,
   input  logic [2:0]             req_first_reg,
   input  logic [2:0]             req_second_reg,
   input  logic [15:0]            req_operand_word,
   input  logic                   item_take,
   output rmeu_pkg::front_out_type front_out
);

   import rmeu_pkg::*;

   localparam int LevelWidth = $clog2(FrontDepth + 1);
   localparam int SumWidth   = LevelWidth + 1;
   localparam int ItemWidth  = $bits(dec_item_type);
   localparam longint unsigned Recip = (64'd1 << 32) / MEM_WORDS;

   logic                  accept;
   dec_item_type          s1_item_ff, s1_item_in;
   logic                  s1_valid_ff;
   logic [15:0]           s1_quot_ff, s1_quot_in;
   logic [47:0]           recip_prod;
   logic [31:0]           quot_times_words;
   logic [31:0]           addr_rem;
   dec_item_type          push_item;
   logic [ItemWidth-1:0]  head_bits;
   logic                  fifo_empty, fifo_full;
   logic [LevelWidth-1:0] fifo_level;

   // wrap a register index to the register file size
   function automatic logic [RegIdxWidth-1:0] reg_wrap(input logic [RegIdxWidth-1:0] idx);
      logic [4:0] v;
      v = {2'b00, idx};
      for (int i = 0; i < 4; i++) begin
         if (v >= 5'(REG_COUNT)) begin
            v = v - 5'(REG_COUNT);
         end
      end
      return v[RegIdxWidth-1:0];
   endfunction

   // reserve queue room for the item in flight
   assign full   = ({1'b0, fifo_level} + SumWidth'(s1_valid_ff)) >= SumWidth'(FrontDepth);
   assign accept = push && !full;

   // classify and start the address reduction
   always_comb begin
      s1_item_in          = '0;
      s1_item_in.cmd      = cmd_type'(req_command);
      s1_item_in.ra       = reg_wrap(req_first_reg);
      s1_item_in.rb       = reg_wrap(req_second_reg);
      s1_item_in.operand  = req_operand_word;
      unique case (cmd_type'(req_command)) inside
         CMD_LOADM: begin
            s1_item_in.mem_rd = 1'b1;
         end
         CMD_POP, CMD_RET: begin
            s1_item_in.mem_rd = 1'b1;
            s1_item_in.use_sp = 1'b1;
         end
         default: begin
            s1_item_in.mem_rd = 1'b0;
         end
      endcase
      recip_prod = 48'(req_operand_word) * 48'(Recip);
      s1_quot_in = recip_prod[47:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= s1_item_in;
         s1_quot_ff <= s1_quot_in;
      end
   end

   // finish the reduction: quotient estimate is low by at most one
   always_comb begin
      quot_times_words = 32'(s1_quot_ff) * 32'(MEM_WORDS);
      addr_rem         = 32'(s1_item_ff.operand) - quot_times_words;
      if (addr_rem >= 32'(MEM_WORDS)) begin
         addr_rem = addr_rem - 32'(MEM_WORDS);
      end
      push_item          = s1_item_ff;
      push_item.mem_addr = addr_rem[15:0];
   end

   rmeu_fifo #(
      .WIDTH (ItemWidth),
      .DEPTH (FrontDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (push_item),
      .pop       (item_take),
      .pop_data  (head_bits),
      .empty     (fifo_empty),
      .full      (fifo_full),
      .level     (fifo_level)
   );

   assign front_out.valid = !fifo_empty;
   assign front_out.item  = dec_item_type'(head_bits);

`ifndef SYNTHESIS
   a_queue_credit: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !fifo_full)
      else $error("front queue overflow");
`endif

endmodule

// File: design/rmeu_back.sv
// ----------------------------------------------------------------------------
// rmeu_back
// Executes classified instructions in two steps: read register file and data
// memory, then compute, write back and queue the result.
// ----------------------------------------------------------------------------
module rmeu_back #(
   parameter int REG_COUNT = 8,
   parameter int MEM_WORDS = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rmeu_pkg::front_out_type front_out,
   output logic                    item_take,
   input  logic                    pop,
   output logic                    empty,
   output logic [15:0]             rsp_written_value,
   output logic [15:0]             rsp_program_counter,
   output logic [15:0]             rsp_stack_pointer,
   output logic                    rsp_zero_flag,
   output logic                    rsp_halted_flag
);

   import rmeu_pkg::*;

   localparam int RaWidth   = $clog2(REG_COUNT);
   localparam int MaWidth   = $clog2(MEM_WORDS);
   localparam int RspWidth  = $bits(rsp_item_type);
   localparam logic [MaWidth-1:0] LastAddr = MaWidth'(MEM_WORDS - 1);
   localparam logic [MaWidth-1:0] WrapAddr = MaWidth'(65535 % MEM_WORDS);

   typedef enum logic [1:0] {
      ST_ISSUE = 2'b01,
      ST_EXEC  = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   dec_item_type          cur_ff;
   logic                  rv_a_ff, rv_b_ff;
   logic [REG_COUNT-1:0]  reg_valid_ff, reg_valid_in;
   logic [15:0]           sp_ff, sp_in;
   logic [MaWidth-1:0]    sp_addr_ff, sp_addr_in;
   logic [15:0]           pc_ff, pc_in;
   logic                  zero_ff, zero_in;
   logic                  halt_ff, halt_in;

   logic [RaWidth-1:0]    rd_addr_a, rd_addr_b, wr_reg_addr;
   logic [MaWidth-1:0]    dm_rd_addr, dm_wr_addr, sp_dec_addr, sp_inc_addr;
   logic [15:0]           rf_a_data, rf_b_data, dm_rd_data;
   logic [15:0]           op_a, op_b, wv;
   logic [31:0]           mul_prod;
   logic                  exec, reg_wr, mem_wr;
   rsp_item_type          rsp_in, rsp_head;
   logic [RspWidth-1:0]   rsp_bits;
   logic                  out_full;
   logic [$clog2(OutDepth+1)-1:0] out_level;

   // issue: take an item when the result queue has room
   assign item_take  = (state_ff == ST_ISSUE) && front_out.valid && !out_full;
   assign exec       = (state_ff == ST_EXEC);
   assign rd_addr_a  = RaWidth'(front_out.item.ra);
   assign rd_addr_b  = RaWidth'(front_out.item.rb);
   assign dm_rd_addr = front_out.item.use_sp ? sp_addr_ff
                                             : MaWidth'(front_out.item.mem_addr);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ISSUE: begin
            if (item_take) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_ISSUE;
         end
         default: begin
            state_in = ST_ISSUE;
         end
      endcase
   end

   // stack address neighbors, tracking the 16-bit wrap of the pointer
   always_comb begin
      if (sp_ff == 16'h0000) begin
         sp_dec_addr = WrapAddr;
      end else if (sp_addr_ff == '0) begin
         sp_dec_addr = LastAddr;
      end else begin
         sp_dec_addr = sp_addr_ff - 1'b1;
      end
      if (sp_ff == 16'hFFFF || sp_addr_ff == LastAddr) begin
         sp_inc_addr = '0;
      end else begin
         sp_inc_addr = sp_addr_ff + 1'b1;
      end
   end

   // execute
   always_comb begin
      op_a         = rv_a_ff ? rf_a_data : 16'h0000;
      op_b         = rv_b_ff ? rf_b_data : 16'h0000;
      mul_prod     = op_a * op_b;
      wv           = 16'h0000;
      reg_wr       = 1'b0;
      mem_wr       = 1'b0;
      dm_wr_addr   = MaWidth'(cur_ff.mem_addr);
      wr_reg_addr  = RaWidth'(cur_ff.ra);
      sp_in        = sp_ff;
      sp_addr_in   = sp_addr_ff;
      pc_in        = pc_ff;
      zero_in      = zero_ff;
      halt_in      = halt_ff;
      reg_valid_in = reg_valid_ff;
      if (exec && !halt_ff) begin
         unique case (cur_ff.cmd)
            CMD_LOAD: begin
               wv     = cur_ff.operand;
               reg_wr = 1'b1;
            end
            CMD_MOV: begin
               wv     = op_b;
               reg_wr = 1'b1;
            end
            CMD_ADD: begin
               wv     = op_a + op_b;
               reg_wr = 1'b1;
            end
            CMD_SUB: begin
               wv     = op_a - op_b;
               reg_wr = 1'b1;
            end
            CMD_MUL: begin
               wv     = mul_prod[15:0];
               reg_wr = 1'b1;
            end
            CMD_HALT: begin
               halt_in = 1'b1;
            end
            CMD_LOADM: begin
               wv     = dm_rd_data;
               reg_wr = 1'b1;
            end
            CMD_STOREM: begin
               wv     = op_a;
               mem_wr = 1'b1;
            end
            CMD_CMP: begin
               zero_in = (op_a == op_b);
            end
            CMD_PUSH: begin
               wv         = op_a;
               mem_wr     = 1'b1;
               dm_wr_addr = sp_dec_addr;
               sp_in      = sp_ff - 1'b1;
               sp_addr_in = sp_dec_addr;
            end
            CMD_JMP: begin
               pc_in = cur_ff.operand;
            end
            CMD_JZ: begin
               if (zero_ff) begin
                  pc_in = cur_ff.operand;
               end
            end
            CMD_POP: begin
               wv         = dm_rd_data;
               reg_wr     = 1'b1;
               sp_in      = sp_ff + 1'b1;
               sp_addr_in = sp_inc_addr;
            end
            CMD_CALL: begin
               wv         = pc_ff;
               mem_wr     = 1'b1;
               dm_wr_addr = sp_dec_addr;
               sp_in      = sp_ff - 1'b1;
               sp_addr_in = sp_dec_addr;
               pc_in      = cur_ff.operand;
            end
            CMD_RET: begin
               pc_in      = dm_rd_data;
               sp_in      = sp_ff + 1'b1;
               sp_addr_in = sp_inc_addr;
            end
            default: begin
               wv = 16'h0000;
            end
         endcase
      end
      if (reg_wr) begin
         reg_valid_in[wr_reg_addr] = 1'b1;
      end
      rsp_in.written_value   = wv;
      rsp_in.program_counter = pc_in;
      rsp_in.stack_pointer   = sp_in;
      rsp_in.zero_flag       = zero_in;
      rsp_in.halted_flag     = halt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ISSUE;
         reg_valid_ff <= '0;
         sp_ff        <= '0;
         sp_addr_ff   <= '0;
         pc_ff        <= '0;
         zero_ff      <= 1'b0;
         halt_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reg_valid_ff <= reg_valid_in;
         sp_ff        <= sp_in;
         sp_addr_ff   <= sp_addr_in;
         pc_ff        <= pc_in;
         zero_ff      <= zero_in;
         halt_ff      <= halt_in;
      end
   end

   // hold the issued item and the valid bits of its source registers
   always_ff @(posedge clock) begin
      if (item_take) begin
         cur_ff  <= front_out.item;
         rv_a_ff <= reg_valid_ff[rd_addr_a];
         rv_b_ff <= reg_valid_ff[rd_addr_b];
      end
   end

   // register file: two copies, one per read port
   rmeu_ram #(
      .WIDTH (16),
      .DEPTH (REG_COUNT)
   ) u_rf_a (
      .clock   (clock),
      .wr_en   (reg_wr),
      .wr_addr (wr_reg_addr),
      .wr_data (wv),
      .rd_en   (item_take),
      .rd_addr (rd_addr_a),
      .rd_data (rf_a_data)
   );

   rmeu_ram #(
      .WIDTH (16),
      .DEPTH (REG_COUNT)
   ) u_rf_b (
      .clock   (clock),
      .wr_en   (reg_wr),
      .wr_addr (wr_reg_addr),
      .wr_data (wv),
      .rd_en   (item_take),
      .rd_addr (rd_addr_b),
      .rd_data (rf_b_data)
   );

   rmeu_ram #(
      .WIDTH (16),
      .DEPTH (MEM_WORDS)
   ) u_dmem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (dm_wr_addr),
      .wr_data (wv),
      .rd_en   (item_take && front_out.item.mem_rd),
      .rd_addr (dm_rd_addr),
      .rd_data (dm_rd_data)
   );

   // result queue
   rmeu_fifo #(
      .WIDTH (RspWidth),
      .DEPTH (OutDepth)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (exec),
      .push_data (rsp_in),
      .pop       (pop),
      .pop_data  (rsp_bits),
      .empty     (empty),
      .full      (out_full),
      .level     (out_level)
   );

   assign rsp_head            = rsp_item_type'(rsp_bits);
   assign rsp_written_value   = rsp_head.written_value;
   assign rsp_program_counter = rsp_head.program_counter;
   assign rsp_stack_pointer   = rsp_head.stack_pointer;
   assign rsp_zero_flag       = rsp_head.zero_flag;
   assign rsp_halted_flag     = rsp_head.halted_flag;

`ifndef SYNTHESIS
   a_result_room: assert property (@(posedge clock) disable iff (reset)
      exec |-> (!out_full && out_level < OutDepth))
      else $error("result transfer into a full queue");
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halted flag cleared");
   a_take_exec: assert property (@(posedge clock) disable iff (reset)
      item_take |=> (state_ff == ST_EXEC))
      else $error("issued item not executed");
   a_halt_no_write: assert property (@(posedge clock) disable iff (reset)
      halt_ff |-> (!reg_wr && !mem_wr))
      else $error("state written after halt");
`endif

endmodule
